@@ src/rht_pkg.sv @@
// ----------------------------------------------------------------------------
// Handle table package
// Shared types, constants and codes for the refcounted handle table.
// ----------------------------------------------------------------------------
package rht_pkg;

    localparam int RES_SLOTS_DEF  = 64;
    localparam int PATH_SLOTS_DEF = 64;

    localparam logic [31:0] NONE_HANDLE = 32'hFFFF_FFFF;
    localparam logic [31:0] MAX_COUNT   = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        TAG_EMPTY = 2'd0,
        TAG_LIVE  = 2'd1,
        TAG_TOMB  = 2'd2
    } t_tag;

    typedef enum logic [2:0] {
        OP_REGISTER = 3'd0,
        OP_RETAIN   = 3'd1,
        OP_RELEASE  = 3'd2,
        OP_LOOKUP   = 3'd3,
        OP_PINSERT  = 3'd4,
        OP_PEVICT   = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_MISS     = 3'd2,
        ST_FULL     = 3'd3,
        ST_OVERFLOW = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_RREQ,
        S_RCHK,
        S_PREQ,
        S_PCHK,
        S_SWEQ,
        S_SWCHK
    } t_state;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] handle;
        logic [63:0] path_key;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] found_handle;
        logic        freed;
        logic [31:0] freed_handle;
    } t_out;

endpackage

@@ src/refcounted_handle_table_with_path_map.sv @@
// An invalid command answers in the cycle after its beat; otherwise each probed
// slot takes a memory read and then a check, and a release that frees a handle
// also sweeps every slot of the path table.
// One item is worked at a time; the next beat is taken once the result is taken.
// Reset starts a clearing pass that marks every slot empty; input is stalled
// until it ends.
// ----------------------------------------------------------------------------
// Refcounted handle table with path map
// Two linear-probing hash tables with tombstones, held in synchronous RAMs.
// Slot counts must be powers of two, unchecked here; a start slot is the low bits.
// ----------------------------------------------------------------------------
module refcounted_handle_table_with_path_map #(
    parameter int RES_SLOTS  = rht_pkg::RES_SLOTS_DEF,
    parameter int PATH_SLOTS = rht_pkg::PATH_SLOTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  rht_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output rht_pkg::t_out o_data
);
    import rht_pkg::*;

    localparam int RW = $clog2(RES_SLOTS);
    localparam int PW = $clog2(PATH_SLOTS);
    localparam int RC = $clog2(RES_SLOTS + 1);
    localparam int PC = $clog2(PATH_SLOTS + 1);

    // Each slot holds its tag next to its payload.
    logic [65:0] m_rmem [RES_SLOTS];   // {tag, handle, count}
    logic [97:0] m_pmem [PATH_SLOTS];  // {tag, key, target}
    logic [65:0] r_rq;
    logic [97:0] r_pq;

    t_state r_st, n_st;
    t_in    r_in, n_in;
    logic [63:0]   r_key, n_key;
    logic [RW-1:0] r_ridx, n_ridx;
    logic [PW-1:0] r_pidx, n_pidx;
    logic [RC-1:0] r_rcnt, n_rcnt;
    logic [PC-1:0] r_pcnt, n_pcnt;
    logic          r_tv, n_tv;
    logic [PW-1:0] r_tomb, n_tomb;
    logic [RW-1:0] r_rtomb, n_rtomb;
    logic [31:0]   r_tgt, n_tgt;        // handle being probed in the resource table
    logic          r_fromlk, n_fromlk;  // resource probe is a lookup retain
    logic          r_ov, n_ov;
    t_out          r_out, n_out;

    logic          rwe, pwe;
    logic [RW-1:0] rwa;
    logic [PW-1:0] pwa;
    logic [65:0]   rwd;
    logic [97:0]   pwd;

    logic [1:0]  rtag_q, ptag_q;
    logic [31:0] q_rh, q_rc, q_pt;
    logic [63:0] q_ph;
    logic        in_acc, in_none;
    logic [63:0] in_key;
    logic        res_stop, res_hit, path_stop, path_hit, rel_zero;
    logic        fin;
    t_out        fin_out;

    assign rtag_q = r_rq[65:64];
    assign q_rh   = r_rq[63:32];
    assign q_rc   = r_rq[31:0];
    assign ptag_q = r_pq[97:96];
    assign q_ph   = r_pq[95:32];
    assign q_pt   = r_pq[31:0];

    // Outputs.
    assign o_stall = (r_st != S_IDLE) || r_ov;
    assign o_valid = r_ov;
    assign o_data  = r_out;

    // Decode of the incoming beat; path keys 0 and all-ones are remapped.
    assign in_acc  = i_valid && !o_stall;
    assign in_none = (i_data.handle == NONE_HANDLE);
    assign in_key  = (i_data.path_key == 64'd0) ? 64'd1 :
                     (i_data.path_key == '1) ? 64'hFFFF_FFFF_FFFF_FFFE :
                     i_data.path_key;

    // Probe step outcomes for the slot just read.
    assign res_stop  = (rtag_q == TAG_EMPTY) || (r_rcnt == RC'(RES_SLOTS));
    assign res_hit   = !res_stop && (rtag_q == TAG_LIVE) && (q_rh == r_tgt);
    assign path_stop = (ptag_q == TAG_EMPTY) || (r_pcnt == PC'(PATH_SLOTS));
    assign path_hit  = !path_stop && (ptag_q == TAG_LIVE) && (q_ph == r_key);
    assign rel_zero  = !r_fromlk && (r_in.op == OP_RELEASE) && (q_rc == 32'd1);

    // Next state.
    always_comb begin
        n_st = r_st;
        case (r_st)
            S_CLR: begin
                if (r_ridx == RW'(RES_SLOTS - 1) && r_pidx == PW'(PATH_SLOTS - 1))
                    n_st = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) begin
                    case (i_data.op)
                        OP_REGISTER, OP_RETAIN, OP_RELEASE: n_st = in_none ? S_IDLE : S_RREQ;
                        OP_PINSERT:           n_st = in_none ? S_IDLE : S_PREQ;
                        OP_LOOKUP, OP_PEVICT: n_st = S_PREQ;
                        default:              n_st = S_IDLE;
                    endcase
                end
            end
            S_RREQ: n_st = S_RCHK;
            S_RCHK: begin
                if (!res_stop && !res_hit) n_st = S_RREQ;
                else if (res_hit && rel_zero) n_st = S_SWEQ;
                else n_st = S_IDLE;
            end
            S_PREQ: n_st = S_PCHK;
            S_PCHK: begin
                if (!path_stop && !path_hit) n_st = S_PREQ;
                else if (path_hit && r_in.op == OP_LOOKUP && q_pt != NONE_HANDLE)
                    n_st = S_RREQ;
                else n_st = S_IDLE;
            end
            S_SWEQ:  n_st = S_SWCHK;
            S_SWCHK: n_st = (r_pidx == PW'(PATH_SLOTS - 1)) ? S_IDLE : S_SWEQ;
            default: n_st = S_IDLE;
        endcase
    end

    // Datapath: probe bookkeeping, memory write-back and the result register.
    always_comb begin
        n_in     = r_in;
        n_key    = r_key;
        n_ridx   = r_ridx;
        n_pidx   = r_pidx;
        n_rcnt   = r_rcnt;
        n_pcnt   = r_pcnt;
        n_tv     = r_tv;
        n_tomb   = r_tomb;
        n_rtomb  = r_rtomb;
        n_tgt    = r_tgt;
        n_fromlk = r_fromlk;
        n_ov     = r_ov;
        n_out    = r_out;
        rwe      = 1'b0;
        rwa      = r_ridx;
        rwd      = '0;
        pwe      = 1'b0;
        pwa      = r_pidx;
        pwd      = '0;
        fin      = 1'b0;
        fin_out  = '0;
        if (r_ov && !i_stall) n_ov = 1'b0;
        case (r_st)
            S_CLR: begin
                // Mark one slot of each table empty per cycle.
                rwe = 1'b1;
                rwd = {TAG_EMPTY, 64'd0};
                pwe = 1'b1;
                pwd = {TAG_EMPTY, 96'd0};
                if (r_ridx != RW'(RES_SLOTS - 1)) n_ridx = r_ridx + 1'b1;
                if (r_pidx != PW'(PATH_SLOTS - 1)) n_pidx = r_pidx + 1'b1;
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_in     = i_data;
                    n_fromlk = 1'b0;
                    n_tv     = 1'b0;
                    n_rcnt   = '0;
                    n_pcnt   = '0;
                    n_tgt    = i_data.handle;
                    n_ridx   = RW'(i_data.handle + 32'd1);
                    n_key    = in_key;
                    n_pidx   = PW'(in_key);
                    case (i_data.op)
                        OP_REGISTER, OP_RETAIN, OP_RELEASE, OP_PINSERT: begin
                            if (in_none) begin
                                fin = 1'b1;
                                fin_out.status = ST_INVALID;
                            end
                        end
                        OP_LOOKUP, OP_PEVICT: fin = 1'b0;
                        default: begin
                            fin = 1'b1;
                            fin_out.status = ST_INVALID;
                        end
                    endcase
                end
            end
            S_RCHK: begin
                // Resource probe step.
                if (res_stop) begin
                    fin = 1'b1;
                    if (r_fromlk) begin
                        // Stale path hit: the path slot is still the one read.
                        pwe = 1'b1;
                        pwd = {TAG_TOMB, q_ph, q_pt};
                        fin_out.status = ST_MISS;
                    end else if (r_in.op == OP_REGISTER) begin
                        if (rtag_q != TAG_EMPTY && !r_tv) begin
                            fin_out.status = ST_FULL;
                        end else begin
                            rwe = 1'b1;
                            rwa = r_tv ? r_rtomb : r_ridx;
                            rwd = {TAG_LIVE, r_tgt, 32'd1};
                            fin_out.status = ST_OK;
                        end
                    end else fin_out.status = ST_MISS;
                end else if (!res_hit) begin
                    if (rtag_q == TAG_TOMB && !r_tv) begin
                        n_tv    = 1'b1;
                        n_rtomb = r_ridx;
                    end
                    n_ridx = (r_ridx == RW'(RES_SLOTS - 1)) ? '0 : r_ridx + 1'b1;
                    n_rcnt = r_rcnt + 1'b1;
                end else begin
                    fin = 1'b1;
                    if (r_fromlk || r_in.op == OP_RETAIN) begin
                        if (q_rc == MAX_COUNT) fin_out.status = ST_OVERFLOW;
                        else begin
                            rwe = 1'b1;
                            rwd = {TAG_LIVE, q_rh, q_rc + 32'd1};
                            fin_out.status = ST_OK;
                            if (r_fromlk) fin_out.found_handle = r_tgt;
                        end
                    end else if (r_in.op == OP_REGISTER) begin
                        fin_out.status = ST_INVALID;
                    end else if (q_rc == 32'd0) begin
                        fin_out.status = ST_INVALID;
                    end else if (rel_zero) begin
                        // Count hits zero: free and sweep the path table.
                        fin    = 1'b0;
                        rwe    = 1'b1;
                        rwd    = {TAG_TOMB, q_rh, 32'd0};
                        n_pidx = '0;
                    end else begin
                        rwe = 1'b1;
                        rwd = {TAG_LIVE, q_rh, q_rc - 32'd1};
                        fin_out.status = ST_OK;
                    end
                end
            end
            S_PCHK: begin
                // Path probe step.
                if (path_stop) begin
                    fin = 1'b1;
                    if (r_in.op == OP_PINSERT) begin
                        if (ptag_q != TAG_EMPTY && !r_tv) begin
                            fin_out.status = ST_FULL;
                        end else begin
                            pwe = 1'b1;
                            pwa = r_tv ? r_tomb : r_pidx;
                            pwd = {TAG_LIVE, r_key, r_in.handle};
                            fin_out.status = ST_OK;
                        end
                    end else fin_out.status = ST_MISS;
                end else if (!path_hit) begin
                    if (ptag_q == TAG_TOMB && !r_tv) begin
                        n_tv   = 1'b1;
                        n_tomb = r_pidx;
                    end
                    n_pidx = (r_pidx == PW'(PATH_SLOTS - 1)) ? '0 : r_pidx + 1'b1;
                    n_pcnt = r_pcnt + 1'b1;
                end else if (r_in.op == OP_PINSERT) begin
                    fin = 1'b1;
                    pwe = 1'b1;
                    pwd = {TAG_LIVE, r_key, r_in.handle};
                    fin_out.status = ST_OK;
                end else if (r_in.op == OP_PEVICT) begin
                    fin = 1'b1;
                    pwe = 1'b1;
                    pwd = {TAG_TOMB, q_ph, q_pt};
                    fin_out.status = ST_OK;
                end else if (q_pt == NONE_HANDLE) begin
                    fin = 1'b1;
                    pwe = 1'b1;
                    pwd = {TAG_TOMB, q_ph, q_pt};
                    fin_out.status = ST_MISS;
                end else begin
                    // Lookup hit: retain the target; the path index is kept.
                    n_fromlk = 1'b1;
                    n_tgt    = q_pt;
                    n_tv     = 1'b0;
                    n_rcnt   = '0;
                    n_ridx   = RW'(q_pt + 32'd1);
                end
            end
            S_SWCHK: begin
                if (ptag_q == TAG_LIVE && q_pt == r_tgt) begin
                    pwe = 1'b1;
                    pwd = {TAG_TOMB, q_ph, q_pt};
                end
                if (r_pidx == PW'(PATH_SLOTS - 1)) begin
                    fin = 1'b1;
                    fin_out.status = ST_OK;
                    fin_out.freed = 1'b1;
                    fin_out.freed_handle = r_tgt;
                end else begin
                    n_pidx = r_pidx + 1'b1;
                end
            end
            default: fin = 1'b0;
        endcase
        if (fin) begin
            n_out = fin_out;
            n_ov  = 1'b1;
        end
    end

    // Resource memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (rwe) m_rmem[rwa] <= rwd;
        r_rq <= m_rmem[r_ridx];
    end

    // Path memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (pwe) m_pmem[pwa] <= pwd;
        r_pq <= m_pmem[r_pidx];
    end

    // Control registers; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_CLR;
            r_ov   <= 1'b0;
            r_ridx <= '0;
            r_pidx <= '0;
        end else begin
            r_st   <= n_st;
            r_ov   <= n_ov;
            r_ridx <= n_ridx;
            r_pidx <= n_pidx;
        end
    end

    // Working registers of the current item.
    always_ff @(posedge i_clk) begin
        r_in     <= n_in;
        r_key    <= n_key;
        r_rcnt   <= n_rcnt;
        r_pcnt   <= n_pcnt;
        r_tv     <= n_tv;
        r_tomb   <= n_tomb;
        r_rtomb  <= n_rtomb;
        r_tgt    <= n_tgt;
        r_fromlk <= n_fromlk;
        r_out    <= n_out;
    end

endmodule

@@ src/rht_checker.sv @@
// ----------------------------------------------------------------------------
// Handle table checker
// Port-level checks on the refcounted handle table.
// ----------------------------------------------------------------------------
module rht_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_stall,
    input logic          o_valid,
    input logic          i_stall,
    input rht_pkg::t_out o_data
);
    import rht_pkg::*;

    // A result beat stays until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result dropped while stalled");

    // No input is taken while a result waits.
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input accepted with pending result");

    // A freed report is always a successful release.
    a_freed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.freed |-> o_data.status == ST_OK)
        else $error("freed with bad status");

    // An accepted beat makes the block busy next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("accept did not start work");

endmodule

bind refcounted_handle_table_with_path_map rht_checker u_rht_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

@@ sim/tb_refcounted_handle_table_with_path_map.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Handle table regression bench
// Drives register, retain, release and path-map commands into the handle
// table, predicts every result from a behavioral copy of both probe tables,
// and checks each result beat in order against that prediction.
// ----------------------------------------------------------------------------
module tb_refcounted_handle_table_with_path_map;

    import rht_pkg::*;

    localparam int NRES      = 64;
    localparam int NPATH     = 64;
    localparam int MAX_CYCLE = 2_000_000;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_stall;
    t_in   i_data;
    logic  o_valid;
    logic  i_stall;
    t_out  o_data;

    refcounted_handle_table_with_path_map dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    // Clock with a 4 ns period.
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Behavioral copy of both tables.
    t_tag        rt_tag [NRES];
    logic [31:0] rt_hdl [NRES];
    logic [31:0] rt_cnt [NRES];
    t_tag        pt_tag [NPATH];
    logic [63:0] pt_key [NPATH];
    logic [31:0] pt_tgt [NPATH];

    t_in   cmd_q[$];
    t_out  result_q[$];
    int    errors;
    int    beats_sent;
    int    beats_seen;
    bit    stim_done;
    bit    drain_hold;
    int    cycle;
    int    in_gap;
    int    out_gap;
    logic [31:0] pool[16];

    // Resource probe: returns the hit slot, or the usable slot, or -1.
    function automatic int res_find(input logic [31:0] h, output bit hit);
        int idx;
        int tomb;
        idx  = int'((h + 33'd1) % NRES);
        tomb = -1;
        hit  = 1'b0;
        for (int i = 0; i < NRES; i++) begin
            if (rt_tag[idx] == TAG_EMPTY) return (tomb >= 0) ? tomb : idx;
            if (rt_tag[idx] == TAG_TOMB) begin
                if (tomb < 0) tomb = idx;
            end else if (rt_hdl[idx] == h) begin
                hit = 1'b1;
                return idx;
            end
            idx = (idx + 1) % NRES;
        end
        return tomb;
    endfunction

    function automatic int path_find(input logic [63:0] k, output bit hit);
        int idx;
        int tomb;
        idx  = int'(k % NPATH);
        tomb = -1;
        hit  = 1'b0;
        for (int i = 0; i < NPATH; i++) begin
            if (pt_tag[idx] == TAG_EMPTY) return (tomb >= 0) ? tomb : idx;
            if (pt_tag[idx] == TAG_TOMB) begin
                if (tomb < 0) tomb = idx;
            end else if (pt_key[idx] == k) begin
                hit = 1'b1;
                return idx;
            end
            idx = (idx + 1) % NPATH;
        end
        return tomb;
    endfunction

    function automatic t_status bump_count(input logic [31:0] h);
        int idx;
        bit hit;
        if (h == NONE_HANDLE) return ST_INVALID;
        idx = res_find(h, hit);
        if (!hit) return ST_MISS;
        if (rt_cnt[idx] == MAX_COUNT) return ST_OVERFLOW;
        rt_cnt[idx]++;
        return ST_OK;
    endfunction

    // Computes the result of one command and updates the table copy.
    function automatic t_out table_update(input t_in c);
        t_out        r;
        logic [63:0] k;
        logic [31:0] h;
        t_status     st;
        int          idx;
        bit          hit;
        r  = '0;
        st = ST_INVALID;
        h  = c.handle;
        k  = c.path_key;
        if (k == '0) k = 64'd1;
        else if (k == '1) k = '1 - 64'd1;
        case (c.op)
            OP_REGISTER: begin
                if (h != NONE_HANDLE) begin
                    idx = res_find(h, hit);
                    if (hit) st = ST_INVALID;
                    else if (idx < 0) st = ST_FULL;
                    else begin
                        rt_tag[idx] = TAG_LIVE;
                        rt_hdl[idx] = h;
                        rt_cnt[idx] = 32'd1;
                        st = ST_OK;
                    end
                end
            end
            OP_RETAIN: st = bump_count(h);
            OP_RELEASE: begin
                if (h != NONE_HANDLE) begin
                    idx = res_find(h, hit);
                    if (!hit) st = ST_MISS;
                    else if (rt_cnt[idx] != 0) begin
                        rt_cnt[idx]--;
                        st = ST_OK;
                        if (rt_cnt[idx] == 0) begin
                            rt_tag[idx] = TAG_TOMB;
                            for (int i = 0; i < NPATH; i++)
                                if (pt_tag[i] == TAG_LIVE && pt_tgt[i] == h)
                                    pt_tag[i] = TAG_TOMB;
                            r.freed        = 1'b1;
                            r.freed_handle = h;
                        end
                    end
                end
            end
            OP_LOOKUP: begin
                idx = path_find(k, hit);
                if (!hit) st = ST_MISS;
                else begin
                    st = bump_count(pt_tgt[idx]);
                    if (st == ST_OK) r.found_handle = pt_tgt[idx];
                    else if (st != ST_OVERFLOW) begin
                        pt_tag[idx] = TAG_TOMB;
                        st = ST_MISS;
                    end
                end
            end
            OP_PINSERT: begin
                if (h != NONE_HANDLE) begin
                    idx = path_find(k, hit);
                    if (!hit && idx < 0) st = ST_FULL;
                    else begin
                        pt_tag[idx] = TAG_LIVE;
                        pt_key[idx] = k;
                        pt_tgt[idx] = h;
                        st = ST_OK;
                    end
                end
            end
            OP_PEVICT: begin
                idx = path_find(k, hit);
                if (hit) begin
                    pt_tag[idx] = TAG_TOMB;
                    st = ST_OK;
                end else st = ST_MISS;
            end
            default: st = ST_INVALID;
        endcase
        r.status = st;
        return r;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        return $urandom_range(0, 3);
    endfunction

    function automatic t_in make_cmd(input t_op op, input logic [31:0] h,
                                     input logic [63:0] k);
        t_in c;
        c.op       = op;
        c.handle   = h;
        c.path_key = k;
        return c;
    endfunction

    // Mostly well-formed traffic on a small handle pool; keys from a small set
    // so lookups hit, plus occasional fully random noise.
    function automatic t_in rand_cmd();
        t_in         c;
        logic [63:0] k;
        k = {$urandom, $urandom};
        if ($urandom_range(0, 9) != 0) k = {k[63:8], 2'b00, 6'($urandom_range(0, 47))};
        c.op = t_op'($urandom_range(0, 5));
        c.handle = pool[$urandom_range(0, 15)];
        c.path_key = k;
        if ($urandom_range(0, 3) != 0) c.path_key = 64'(c.handle) * 64'h9E37 + 64'($urandom_range(0, 3));
        if ($urandom_range(0, 49) == 0) c.handle = NONE_HANDLE;
        if ($urandom_range(0, 49) == 0) begin
            c.op       = 3'($urandom_range(0, 7));
            c.handle   = $urandom;
            c.path_key = {$urandom, $urandom};
        end
        return c;
    endfunction

    // Driver: presents queued commands with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            in_gap  <= 0;
        end else if (i_valid && !o_stall) begin
            beats_sent <= beats_sent + 1;
            if (cmd_q.size() > 0 && pick_gap() == 0 && !drain_hold) begin
                i_data <= cmd_q.pop_front();
            end else begin
                i_valid <= 1'b0;
                in_gap  <= pick_gap();
            end
        end else if (!i_valid) begin
            if (in_gap > 0) in_gap <= in_gap - 1;
            else if (cmd_q.size() > 0 && !drain_hold) begin
                i_valid <= 1'b1;
                i_data  <= cmd_q.pop_front();
            end
        end
    end

    // Prediction at the accepting edge, in the same order as the driver.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) result_q.push_back(table_update(i_data));
    end

    // Monitor: random stalls and in-order result checks.
    always @(posedge i_clk) begin
        t_out exp_r;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            out_gap <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                beats_seen <= beats_seen + 1;
                if (result_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    errors++;
                end else begin
                    exp_r = result_q.pop_front();
                    if (o_data.status !== exp_r.status) begin
                        $error("status: expected %0d, got %0d", exp_r.status,
                               o_data.status);
                        errors++;
                    end
                    if (o_data.found_handle !== exp_r.found_handle) begin
                        $error("found_handle: expected %h, got %h",
                               exp_r.found_handle, o_data.found_handle);
                        errors++;
                    end
                    if (o_data.freed !== exp_r.freed) begin
                        $error("freed: expected %b, got %b", exp_r.freed, o_data.freed);
                        errors++;
                    end
                    if (o_data.freed_handle !== exp_r.freed_handle) begin
                        $error("freed_handle: expected %h, got %h",
                               exp_r.freed_handle, o_data.freed_handle);
                        errors++;
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                i_stall <= 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                out_gap <= pick_gap();
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial begin
        errors     = 0;
        beats_sent = 0;
        beats_seen = 0;
        cycle      = 0;
        drain_hold = 1'b0;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_stall    = 1'b0;
        i_data     = '0;
        for (int i = 0; i < NRES; i++) begin
            rt_tag[i] = TAG_EMPTY;
            rt_hdl[i] = '0;
            rt_cnt[i] = '0;
        end
        for (int i = 0; i < NPATH; i++) begin
            pt_tag[i] = TAG_EMPTY;
            pt_key[i] = '0;
            pt_tgt[i] = '0;
        end
        pool[0] = 32'h0;
        pool[1] = 32'hFFFF_FFFE;
        pool[2] = 32'h8000_0000;
        pool[3] = 32'h7FFF_FFFF;
        for (int i = 4; i < 16; i++) pool[i] = $urandom;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: special cases and field extremes.
        cmd_q.push_back(make_cmd(OP_REGISTER, NONE_HANDLE, '0));
        cmd_q.push_back(make_cmd(OP_REGISTER, 32'h0, '0));
        cmd_q.push_back(make_cmd(OP_REGISTER, 32'h0, '0));
        cmd_q.push_back(make_cmd(OP_REGISTER, 32'hFFFF_FFFE, '1));
        cmd_q.push_back(make_cmd(OP_RETAIN, 32'h0, '0));
        cmd_q.push_back(make_cmd(OP_RETAIN, NONE_HANDLE, '0));
        cmd_q.push_back(make_cmd(OP_RETAIN, 32'h1234, '0));
        cmd_q.push_back(make_cmd(OP_PINSERT, 32'h0, '0));
        cmd_q.push_back(make_cmd(OP_PINSERT, 32'hFFFF_FFFE, '1));
        cmd_q.push_back(make_cmd(OP_PINSERT, NONE_HANDLE, 64'h5));
        cmd_q.push_back(make_cmd(OP_LOOKUP, NONE_HANDLE, 64'd1));
        cmd_q.push_back(make_cmd(OP_LOOKUP, 32'h0, '1 - 64'd1));
        cmd_q.push_back(make_cmd(OP_PINSERT, 32'h4321, 64'd1));
        cmd_q.push_back(make_cmd(OP_LOOKUP, 32'h0, '0));
        cmd_q.push_back(make_cmd(OP_PINSERT, 32'h0, 64'd1));
        cmd_q.push_back(make_cmd(OP_RELEASE, 32'h0, '0));
        cmd_q.push_back(make_cmd(OP_RELEASE, 32'h0, '0));
        cmd_q.push_back(make_cmd(OP_RELEASE, 32'h0, '0));
        cmd_q.push_back(make_cmd(OP_LOOKUP, 32'h0, 64'd1));
        cmd_q.push_back(make_cmd(OP_PEVICT, 32'h0, '1));
        cmd_q.push_back(make_cmd(OP_PEVICT, 32'h0, '1));
        cmd_q.push_back(make_cmd(OP_RELEASE, NONE_HANDLE, '0));
        cmd_q.push_back(t_in'({3'd6, 32'h0, 64'h0}));
        cmd_q.push_back(t_in'({3'd7, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}));
        wait (cmd_q.size() == 0);

        // Hold off the sender until every expected result is back.
        drain_hold = 1'b1;
        wait (result_q.size() == 0 && !i_valid);
        drain_hold = 1'b0;

        // Fill the resource table to force table full, then drain it.
        for (int i = 0; i < 70; i++) cmd_q.push_back(make_cmd(OP_REGISTER, 32'h1000 + i, '0));
        for (int i = 0; i < 70; i++) cmd_q.push_back(make_cmd(OP_PINSERT, 32'h1000 + i, 64'h100 + i));
        for (int i = 0; i < 70; i++) cmd_q.push_back(make_cmd(OP_RELEASE, 32'h1000 + i, '0));

        // Random traffic.
        for (int i = 0; i < 950; i++) cmd_q.push_back(rand_cmd());
        wait (cmd_q.size() == 0 && !i_valid);
        wait (result_q.size() == 0);
        repeat (2 * NRES + 2 * NPATH + 8) @(posedge i_clk);

        $display("Covered %0d command beats and %0d result beats, including full tables,",
                 beats_sent, beats_seen);
        $display("stale path hits, frees with path sweeps and invalid commands.");
        if (errors == 0 && result_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/rht_pkg.sv
src/refcounted_handle_table_with_path_map.sv
src/rht_checker.sv
sim/tb_refcounted_handle_table_with_path_map.sv
